### src/ssvf_pkg.sv
// ----------------------------------------------------------------------------
// ssvf_pkg
// Shared types, constants and helpers of the stereo state-variable lowpass.
// ----------------------------------------------------------------------------
package ssvf_pkg;

    localparam int ACC_W      = 32;
    localparam int V_W        = 40;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COEF_A1   = 3'd0,
        REG_COEF_A2   = 3'd1,
        REG_COEF_A3   = 3'd2,
        REG_ENABLE    = 3'd3,
        REG_GAIN      = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_UPD,
        ST_GAIN,
        ST_SAT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic upd;
        logic gain;
    } t_lane_ctrl;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [V_W-1:0] v);
        logic signed [V_W-1:0] hi;
        logic signed [V_W-1:0] lo;
        hi = {{(V_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[ACC_W-1:0];
        end else if (v < lo) begin
            return lo[ACC_W-1:0];
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

### src/ssvf_cfg.sv
// ----------------------------------------------------------------------------
// ssvf_cfg
// Register file for the filter coefficients, enable bit and output gain.
// ----------------------------------------------------------------------------
module ssvf_cfg #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ssvf_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ssvf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic [COEF_FRAC_BITS-1:0]           o_a1,
    output logic [COEF_FRAC_BITS-1:0]           o_a2,
    output logic [COEF_FRAC_BITS-1:0]           o_a3,
    output logic                                o_enable,
    output logic [ssvf_pkg::GAIN_W-1:0]         o_gain
);
    import ssvf_pkg::*;

    logic [COEF_FRAC_BITS-1:0] r_a1;
    logic [COEF_FRAC_BITS-1:0] r_a2;
    logic [COEF_FRAC_BITS-1:0] r_a3;
    logic                      r_enable;
    logic [GAIN_W-1:0]         r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1     <= '0;
            r_a2     <= '0;
            r_a3     <= '0;
            r_enable <= 1'b0;
            r_gain   <= GAIN_UNITY;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_COEF_A1: r_a1     <= i_cfg_data[COEF_FRAC_BITS-1:0];
                REG_COEF_A2: r_a2     <= i_cfg_data[COEF_FRAC_BITS-1:0];
                REG_COEF_A3: r_a3     <= i_cfg_data[COEF_FRAC_BITS-1:0];
                REG_ENABLE:  r_enable <= i_cfg_data[0];
                REG_GAIN:    r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_a1     = r_a1;
    assign o_a2     = r_a2;
    assign o_a3     = r_a3;
    assign o_enable = r_enable;
    assign o_gain   = r_gain;

endmodule

### src/ssvf_lane.sv
// ----------------------------------------------------------------------------
// ssvf_lane
// One channel: trapezoidal state-variable lowpass, output gain and saturation.
// ----------------------------------------------------------------------------
module ssvf_lane #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssvf_pkg::t_lane_ctrl               i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_x,
    input  logic [COEF_FRAC_BITS-1:0]          i_a1,
    input  logic [COEF_FRAC_BITS-1:0]          i_a2,
    input  logic [COEF_FRAC_BITS-1:0]          i_a3,
    input  logic                               i_enable,
    input  logic [ssvf_pkg::GAIN_W-1:0]        i_gain,
    output logic signed [SAMPLE_WIDTH-1:0]     o_y
);
    import ssvf_pkg::*;

    localparam int CW    = COEF_FRAC_BITS;
    localparam int PW    = CW + V_W;
    localparam int PRD_W = V_W + GAIN_W + 1;

    localparam logic signed [PW-1:0] C_HALF =
        {{(PW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};
    localparam logic signed [PRD_W-1:0] G_HALF =
        {{(PRD_W-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};
    localparam logic signed [PRD_W-1:0] OUT_HI =
        {{(PRD_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [PRD_W-1:0] OUT_LO = ~OUT_HI;

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [ACC_W-1:0]        r_c0;
    logic signed [ACC_W-1:0]        r_c1;
    logic signed [ACC_W:0]          r_v3;
    logic signed [CW+ACC_W:0]       r_m0;
    logic signed [CW+ACC_W+1:0]     r_m1;
    logic signed [CW+ACC_W:0]       r_m2;
    logic signed [CW+ACC_W+1:0]     r_m3;
    logic signed [V_W-1:0]          r_v1;
    logic signed [V_W-1:0]          r_v2;
    logic signed [PRD_W-1:0]        r_prod;

    logic signed [CW:0]             a1_s;
    logic signed [CW:0]             a2_s;
    logic signed [CW:0]             a3_s;
    logic signed [GAIN_W:0]         gain_s;
    logic signed [ACC_W:0]          v3;
    logic signed [PW-1:0]           s01;
    logic signed [PW-1:0]           s23;
    logic signed [PW-1:0]           s01_sh;
    logic signed [PW-1:0]           s23_sh;
    logic signed [V_W-1:0]          y_sel;
    logic signed [V_W-1:0]          c0_next;
    logic signed [V_W-1:0]          c1_next;
    logic signed [PRD_W-1:0]        rnd;
    logic signed [PRD_W-1:0]        rnd_sh;

    always_comb begin
        a1_s    = {1'b0, i_a1};
        a2_s    = {1'b0, i_a2};
        a3_s    = {1'b0, i_a3};
        gain_s  = {1'b0, i_gain};
        v3      = (ACC_W+1)'(r_x) - (ACC_W+1)'(r_c1);
        s01     = PW'(r_m0) + PW'(r_m1) + C_HALF;
        s23     = PW'(r_m2) + PW'(r_m3) + C_HALF;
        s01_sh  = s01 >>> CW;
        s23_sh  = s23 >>> CW;
        y_sel   = i_enable ? r_v2 : V_W'(r_x);
        c0_next = (r_v1 <<< 1) - V_W'(r_c0);
        c1_next = (r_v2 <<< 1) - V_W'(r_c1);
        rnd     = r_prod + G_HALF;
        rnd_sh  = rnd >>> GAIN_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
        end else if (i_ctrl.gain && i_enable) begin
            r_c0 <= sat_acc(c0_next);
            r_c1 <= sat_acc(c1_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x <= i_x;
        end
        if (i_ctrl.mul_a) begin
            r_v3 <= v3;
            r_m0 <= a1_s * r_c0;
            r_m1 <= a2_s * v3;
        end
        if (i_ctrl.mul_b) begin
            r_m2 <= a2_s * r_c0;
            r_m3 <= a3_s * r_v3;
            r_v1 <= s01_sh[V_W-1:0];
        end
        if (i_ctrl.upd) begin
            r_v2 <= V_W'(r_c1) + s23_sh[V_W-1:0];
        end
        if (i_ctrl.gain) begin
            r_prod <= y_sel * gain_s;
        end
    end

    always_comb begin
        if (rnd_sh > OUT_HI) begin
            o_y = OUT_HI[SAMPLE_WIDTH-1:0];
        end else if (rnd_sh < OUT_LO) begin
            o_y = OUT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            o_y = rnd_sh[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

### src/ssvf_merge.sv
// ----------------------------------------------------------------------------
// ssvf_merge
// Joins the two lane results into one output request and holds it for the
// receiver.
// ----------------------------------------------------------------------------
module ssvf_merge #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int TDATA_W      = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right,
    output logic                           o_free,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [TDATA_W-1:0]             m_axis_tdata
);
    import ssvf_pkg::*;

    logic                     r_valid;
    logic [TDATA_W-1:0]       r_data;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= TDATA_W'({i_right, i_left});
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

endmodule

### src/stereo_svf_lowpass_unit.sv
// ----------------------------------------------------------------------------
// stereo_svf_lowpass_unit
// Stereo trapezoidal state-variable lowpass with output gain, one lane per
// channel.
//
// Samples enter as one request on s_axis: left in the low bits, right above.
// Results leave as one request on m_axis in the same layout, saturated to the
// sample width. Coefficients, the enable bit and the gain are written through
// the cfg channel, which is always ready; write it only while the block is
// idle. A request is accepted in the idle state. It then runs through five
// stages, two multiplier passes for the filter, one integrator step, one gain
// multiply and one rounding step; the last stage loads the result into the
// output register. Only then does the block return to idle and take the next
// request, so a new stereo pair is not taken before the last one is through.
// When the receiver stalls, the output register holds the result and the
// block accepts one more request, which waits in its last stage until the
// register is free. Reset clears the integrators, sets the coefficients and
// enable to zero and the gain to unity.
// ----------------------------------------------------------------------------
module stereo_svf_lowpass_unit #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0: in_left, in_right, zero padding.
    input  logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // Fields from bit 0: out_left, out_right, zero padding.
    output logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [ssvf_pkg::CFG_ADDR_W-1:0]           i_cfg_addr,
    input  logic [ssvf_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import ssvf_pkg::*;

    localparam int TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

    t_state                         r_state;
    t_state                         n_state;
    t_lane_ctrl                     lane_ctrl;
    logic                           merge_load;
    logic                           merge_free;
    logic [COEF_FRAC_BITS-1:0]      a1;
    logic [COEF_FRAC_BITS-1:0]      a2;
    logic [COEF_FRAC_BITS-1:0]      a3;
    logic                           enable;
    logic [GAIN_W-1:0]              gain;
    logic signed [SAMPLE_WIDTH-1:0] y_left;
    logic signed [SAMPLE_WIDTH-1:0] y_right;

    ssvf_cfg #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_a1        (a1),
        .o_a2        (a2),
        .o_a3        (a3),
        .o_enable    (enable),
        .o_gain      (gain)
    );

    ssvf_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (lane_ctrl),
        .i_x      (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_a1     (a1),
        .i_a2     (a2),
        .i_a3     (a3),
        .i_enable (enable),
        .i_gain   (gain),
        .o_y      (y_left)
    );

    ssvf_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (lane_ctrl),
        .i_x      (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_a1     (a1),
        .i_a2     (a2),
        .i_a3     (a3),
        .i_enable (enable),
        .i_gain   (gain),
        .o_y      (y_right)
    );

    ssvf_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TDATA_W      (TDATA_W)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (merge_load),
        .i_left        (y_left),
        .i_right       (y_right),
        .o_free        (merge_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_MUL_A;
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_UPD;
            ST_UPD:   n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_SAT;
            ST_SAT:   if (merge_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        lane_ctrl     = '0;
        merge_load    = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready  = 1'b1;
                lane_ctrl.load = s_axis_tvalid;
            end
            ST_MUL_A: lane_ctrl.mul_a = 1'b1;
            ST_MUL_B: lane_ctrl.mul_b = 1'b1;
            ST_UPD:   lane_ctrl.upd   = 1'b1;
            ST_GAIN:  lane_ctrl.gain  = 1'b1;
            ST_SAT:   merge_load      = merge_free;
            default: begin
            end
        endcase
    end

    a_valid_from_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_SAT)
        else $error("Output became valid without a finished request.");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == ST_MUL_A)
        else $error("Accepted request did not start the lanes.");

    a_sat_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SAT && !merge_free |=> r_state == ST_SAT)
        else $error("Result left its stage while the output was occupied.");

endmodule

### verif/stereo_svf_lowpass_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_svf_lowpass_unit_tb
// Self-checking bench for the stereo state-variable lowpass. A scoreboard
// class keeps its own copy of the coefficients, gain, enable bit and the four
// integrators. It predicts each output pair when an input request is
// accepted and compares every output request against the oldest prediction.
// A short directed part covers full-scale samples, gain extremes, the largest
// coefficients, bypass with held integrators, register masking and unmapped
// register writes. It is followed by randomized phases, each with its own
// filter setting. Random stalls are applied on both stream sides.
// ----------------------------------------------------------------------------
module stereo_svf_lowpass_unit_tb;

    import ssvf_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 16;
    localparam int TDATA_W     = 2 * SAMPLE_W;
    localparam int NUM_PHASES  = 14;
    localparam int PHASE_ITEMS = 130;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 40;

    localparam logic [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] MINUS_ONE = {SAMPLE_W{1'b1}};
    localparam logic [COEF_W-1:0]   COEF_MAX = {COEF_W{1'b1}};
    localparam logic [CFG_ADDR_W-1:0] FIRST_UNMAPPED_REG = 3'd5;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint INTEG_MAX  = 64'sd2147483647;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;

    class svf_scoreboard;
        logic [COEF_W-1:0] coef_a1;
        logic [COEF_W-1:0] coef_a2;
        logic [COEF_W-1:0] coef_a3;
        logic [GAIN_W-1:0] gain;
        logic              enabled;
        longint            integ [2][2];
        logic [TDATA_W-1:0] expected_pairs [$];
        int                errors;
        int                results_seen;

        function new();
            coef_a1 = '0;
            coef_a2 = '0;
            coef_a3 = '0;
            gain    = GAIN_UNITY;
            enabled = 1'b0;
            foreach (integ[c, k]) integ[c][k] = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_COEF_A1: coef_a1 = data[COEF_W-1:0];
                REG_COEF_A2: coef_a2 = data[COEF_W-1:0];
                REG_COEF_A3: coef_a3 = data[COEF_W-1:0];
                REG_ENABLE:  enabled = data[0];
                REG_GAIN:    gain    = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint filter_channel(int ch, longint x);
            longint c0;
            longint c1;
            longint v1;
            longint v2;
            longint v3;
            if (!enabled) return x;
            c0 = integ[ch][0];
            c1 = integ[ch][1];
            v3 = x - c1;
            v1 = round_shift(longint'(coef_a1) * c0 + longint'(coef_a2) * v3, COEF_W);
            v2 = c1 + round_shift(longint'(coef_a2) * c0 + longint'(coef_a3) * v3, COEF_W);
            integ[ch][0] = clamp(2 * v1 - c0, INTEG_MIN, INTEG_MAX);
            integ[ch][1] = clamp(2 * v2 - c1, INTEG_MIN, INTEG_MAX);
            return v2;
        endfunction

        function logic [SAMPLE_W-1:0] scale_output(longint y);
            longint p;
            p = round_shift(y * longint'(gain), GAIN_FRAC);
            p = clamp(p, SAMPLE_MIN, SAMPLE_MAX);
            return p[SAMPLE_W-1:0];
        endfunction

        function void note_request(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right);
            longint xl;
            longint xr;
            logic [SAMPLE_W-1:0] yl;
            logic [SAMPLE_W-1:0] yr;
            xl = $signed(left);
            xr = $signed(right);
            yl = scale_output(filter_channel(0, xl));
            yr = scale_output(filter_channel(1, xr));
            expected_pairs.push_back({yr, yl});
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
        endtask

        task check_result(logic [TDATA_W-1:0] got);
            logic [TDATA_W-1:0] want;
            results_seen++;
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          results_seen));
                return;
            end
            want = expected_pairs.pop_front();
            if (got[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0]) begin
                report_mismatch($sformatf("result %0d out_left got %0d expected %0d",
                                          results_seen, $signed(got[SAMPLE_W-1:0]),
                                          $signed(want[SAMPLE_W-1:0])));
            end
            if (got[TDATA_W-1:SAMPLE_W] !== want[TDATA_W-1:SAMPLE_W]) begin
                report_mismatch($sformatf("result %0d out_right got %0d expected %0d",
                                          results_seen, $signed(got[TDATA_W-1:SAMPLE_W]),
                                          $signed(want[TDATA_W-1:SAMPLE_W])));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    svf_scoreboard sb;
    logic          sender_calm;

    stereo_svf_lowpass_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] prev);
        int          r;
        int          s;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        if (r < 3) return FULL_POS;
        if (r < 6) return FULL_NEG;
        if (r < 8) return '0;
        if (r < 9) return MINUS_ONE;
        if (r < 35) return prev;
        if (r < 60) begin
            s = $urandom_range(0, 8191) - 4096;
            return s[SAMPLE_W-1:0];
        end
        w = $urandom();
        return w[SAMPLE_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] to_q16(longint v);
        return (v > longint'(COEF_MAX)) ? COEF_MAX : v[COEF_W-1:0];
    endfunction

    // Coefficients derived from a random g and a random damping k.
    function automatic void design_lowpass(output logic [COEF_W-1:0] a1,
                                           output logic [COEF_W-1:0] a2,
                                           output logic [COEF_W-1:0] a3);
        longint g;
        longint k;
        longint den;
        g   = $urandom_range(300, 400000);
        k   = $urandom_range(3000, 131072);
        den = 65536 + ((g * (g + k)) >>> 16);
        a1  = to_q16((longint'(1) <<< 32) / den);
        a2  = to_q16((g * longint'(a1)) >>> 16);
        a3  = to_q16((g * longint'(a2)) >>> 16);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_addr  = addr;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(addr, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_filter(input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                                  input logic [COEF_W-1:0] a3, input logic en,
                                  input logic [GAIN_W-1:0] gain);
        write_reg(REG_COEF_A1, ($urandom() & 32'hFFFF_0000) | 32'(a1));
        write_reg(REG_COEF_A2, ($urandom() & 32'hFFFF_0000) | 32'(a2));
        if ($urandom_range(0, 2) == 0) begin
            write_reg(FIRST_UNMAPPED_REG + 3'($urandom_range(0, 2)), $urandom());
        end
        write_reg(REG_COEF_A3, ($urandom() & 32'hFFFF_0000) | 32'(a3));
        write_reg(REG_ENABLE, ($urandom() & 32'hFFFF_FFFE) | 32'(en));
        write_reg(REG_GAIN, ($urandom() & 32'hFFFF_0000) | 32'(gain));
    endtask

    task automatic push_pair(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
        int gap;
        s_axis_tdata  = {right, left};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(left, right);
        @(negedge i_clk);
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (calm > 0) begin
                calm--;
            end else if ($urandom_range(0, 299) == 0) begin
                calm = $urandom_range(40, 250);
            end
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                if (calm == 0 && $urandom_range(0, 99) < 30) stall = pick_gap();
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [COEF_W-1:0]   a1;
        logic [COEF_W-1:0]   a2;
        logic [COEF_W-1:0]   a3;
        logic                en;
        logic [GAIN_W-1:0]   gain;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        int                  mode;

        sb            = new();
        sender_calm   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset state: bypass at unity gain.
        push_pair(FULL_POS, FULL_NEG);
        push_pair(FULL_NEG, FULL_POS);
        push_pair('0, MINUS_ONE);
        push_pair(24'd1, '0);

        // Highest gain drives the output into saturation.
        settle();
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        push_pair(FULL_POS, FULL_NEG);
        push_pair(MINUS_ONE, 24'd1);
        push_pair(24'h400000, 24'hC00000);
        settle();
        write_reg(REG_GAIN, 32'hABCD_0000);
        push_pair(FULL_POS, FULL_NEG);

        // Largest coefficients with full-scale input drive the integrators far from zero.
        settle();
        write_reg(REG_GAIN, 32'(GAIN_UNITY));
        write_reg(REG_COEF_A1, 32'h5A5A_FFFF);
        write_reg(REG_COEF_A2, 32'hFFFF_FFFF);
        write_reg(REG_COEF_A3, 32'h0001_FFFF);
        write_reg(REG_ENABLE, 32'hFFFF_FFFE);
        write_reg(REG_ENABLE, 32'h0000_0003);
        repeat (3) push_pair(FULL_POS, FULL_NEG);
        repeat (3) push_pair(FULL_NEG, FULL_POS);

        // Bypass keeps the integrators, which resume once the filter is back on.
        settle();
        write_reg(REG_ENABLE, '0);
        write_reg(FIRST_UNMAPPED_REG, 32'hFFFF_FFFF);
        push_pair(24'h123456, 24'hEDCBA9);
        push_pair(MINUS_ONE, FULL_POS);
        settle();
        write_reg(REG_ENABLE, 32'h1);
        push_pair(24'h000100, 24'hFFFF00);
        push_pair('0, '0);

        // Zero coefficients: the first integrator flips sign, the second holds.
        settle();
        program_filter('0, '0, '0, 1'b1, GAIN_UNITY);
        push_pair(FULL_POS, 24'd7);
        push_pair(FULL_NEG, MINUS_ONE);

        left  = '0;
        right = '0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            design_lowpass(a1, a2, a3);
            en   = 1'b1;
            gain = GAIN_UNITY;
            case (phase)
                0: gain = {GAIN_W{1'b1}};
                1: begin
                    a1 = COEF_MAX;
                    a2 = COEF_MAX;
                    a3 = COEF_MAX;
                end
                2: begin
                    a1   = '0;
                    a2   = '0;
                    a3   = '0;
                    gain = GAIN_W'($urandom_range(8192, 24576));
                end
                3: begin
                    en   = 1'b0;
                    gain = '0;
                end
                default: begin
                    mode = $urandom_range(0, 9);
                    if (mode == 0) begin
                        en = 1'b0;
                    end else if (mode == 1) begin
                        a1 = COEF_W'($urandom());
                        a2 = COEF_W'($urandom());
                        a3 = COEF_W'($urandom());
                    end
                    mode = $urandom_range(0, 9);
                    if (mode == 0) begin
                        gain = {GAIN_W{1'b1}};
                    end else if (mode == 1) begin
                        gain = GAIN_W'($urandom());
                    end else if (mode < 5) begin
                        gain = GAIN_W'($urandom_range(8192, 24576));
                    end
                end
            endcase
            program_filter(a1, a2, a3, en, gain);
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ((phase == 5 || phase == 10) && i == PHASE_ITEMS / 2) settle();
                left  = pick_sample(left);
                right = pick_sample(right);
                push_pair(left, right);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
src/ssvf_pkg.sv
src/ssvf_cfg.sv
src/ssvf_lane.sv
src/ssvf_merge.sv
src/stereo_svf_lowpass_unit.sv
verif/stereo_svf_lowpass_unit_tb.sv
